### hdl/cdd_pkg.sv
// Shared types, constants, microcode encodings and calendar tables for the date difference block.
`default_nettype none
package cdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ORDER_W = 2;
    localparam int DIST_W  = 22;
    localparam int SER_W   = 23;   // day serial of any 14-bit year
    localparam int MUL_W   = 15;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int PC_W    = 4;

    // floor(x / 100) = (x * RECIP100) >> 21, exact for x below 43690
    localparam logic [MUL_W-1:0]  RECIP100 = 15'd20972;
    localparam logic [MUL_W-1:0]  DAYS_YEAR = 15'd365;
    localparam logic [DIST_W-1:0] DAYS_MAX = 22'h3FFFFF;

    // multiplier operand select
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_Y99  = 3'd1;
    localparam logic [2:0] MUL_Y    = 3'd2;
    localparam logic [2:0] MUL_Y399 = 3'd3;
    localparam logic [2:0] MUL_Y365 = 3'd4;

    // accumulator operations
    localparam logic [2:0] ACC_NOP      = 3'd0;
    localparam logic [2:0] ACC_LOAD_Q4  = 3'd1;
    localparam logic [2:0] ACC_SUB_Q    = 3'd2;
    localparam logic [2:0] ACC_ADD_Q400 = 3'd3;
    localparam logic [2:0] ACC_ADD_PROD = 3'd4;
    localparam logic [2:0] ACC_ADD_MON  = 3'd5;
    localparam logic [2:0] ACC_ABSDIFF  = 3'd6;

    // flag register operations
    localparam logic [2:0] AUX_NONE   = 3'd0;
    localparam logic [2:0] AUX_Q100   = 3'd1;
    localparam logic [2:0] AUX_CHK100 = 3'd2;
    localparam logic [2:0] AUX_LEAP   = 3'd3;
    localparam logic [2:0] AUX_VALID  = 3'd4;

    typedef struct packed {
        logic [2:0]      mul_sel;
        logic [2:0]      acc_op;
        logic [2:0]      aux_op;
        logic            store;    // keep first serial
        logic            branch;   // back to target on first pass
        logic            last;     // write result word
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic   run;   // execute current word this cycle
        logic   sel;   // 0: first date, 1: second date
        t_uword w;
    } t_ctl;

    function automatic logic [8:0] f_mon_start(input logic [MONTH_W-1:0] m);
        logic [8:0] s;
        case (m)
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [DAY_W-1:0] f_mon_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

### hdl/cdd_if.sv
// Handshake interfaces for the date pair input and the result output.
`default_nettype none
interface cdd_in_if;
    logic                          valid;
    logic                          ready;
    logic [cdd_pkg::DAY_W-1:0]     day_a;
    logic [cdd_pkg::MONTH_W-1:0]   month_a;
    logic [cdd_pkg::YEAR_W-1:0]    year_a;
    logic [cdd_pkg::DAY_W-1:0]     day_b;
    logic [cdd_pkg::MONTH_W-1:0]   month_b;
    logic [cdd_pkg::YEAR_W-1:0]    year_b;

    modport source (output valid, day_a, month_a, year_a, day_b, month_b, year_b,
                    input ready);
    modport sink   (input valid, day_a, month_a, year_a, day_b, month_b, year_b,
                    output ready);
endinterface

interface cdd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cdd_pkg::ORDER_W-1:0] order;
    logic [cdd_pkg::DIST_W-1:0]         days_apart;
    logic                               first_valid;
    logic                               second_valid;

    modport source (output valid, order, days_apart, first_valid, second_valid,
                    input ready);
    modport sink   (input valid, order, days_apart, first_valid, second_valid,
                    output ready);
endinterface
`default_nettype wire

### hdl/calendar_date_difference.sv
// Top level of the Gregorian date difference block.
// Takes a pair of dates and returns their order, the day distance (0 if either date is
// invalid, saturating at 4194303) and a validity flag per date. A small microprogram of
// nine steps drives one shared 15x15 multiplier and a 23-bit accumulator: seven steps
// build the day serial of each date in turn (leap counts come from multiplying by a
// reciprocal of 100), then one step forms the absolute difference and one writes the
// result word. A new word is taken the cycle after the result is written, so a word is
// not taken while the previous one is still running its steps. The result register lets
// the next word start while the previous result waits; the final step stalls only if it
// is still occupied.
`default_nettype none
module calendar_date_difference (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cdd_in_if.sink      i_in,
    cdd_out_if.source   o_out
);

    cdd_pkg::t_ctl ctl;
    logic          busy;
    logic          hold;
    logic          in_accept;

    assign i_in.ready = !busy;
    assign in_accept  = i_in.valid && !busy;

    cdd_useq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_hold  (hold),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    cdd_dpath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_accept),
        .i_day_a        (i_in.day_a),
        .i_month_a      (i_in.month_a),
        .i_year_a       (i_in.year_a),
        .i_day_b        (i_in.day_b),
        .i_month_b      (i_in.month_b),
        .i_year_b       (i_in.year_b),
        .i_ctl          (ctl),
        .i_out_ready    (o_out.ready),
        .o_hold         (hold),
        .o_out_valid    (o_out.valid),
        .o_order        (o_out.order),
        .o_days_apart   (o_out.days_apart),
        .o_first_valid  (o_out.first_valid),
        .o_second_valid (o_out.second_valid)
    );

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> busy)
        else $error("accepted word did not start the step program");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(ctl.run && ctl.w.last))
        else $error("result word appeared without the final step");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !(o_out.first_valid && o_out.second_valid))
            |-> (o_out.days_apart == '0))
        else $error("distance not zero for an invalid date");

    a_no_last_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.run && ctl.w.last) |-> !(o_out.valid && !o_out.ready))
        else $error("result register overwritten while still held");

endmodule
`default_nettype wire

### hdl/cdd_useq.sv
// Microcode sequencer: program ROM, step counter, date pass select and jump logic.
`default_nettype none
module cdd_useq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_hold,    // result register still occupied
    output cdd_pkg::t_ctl      o_ctl,
    output logic               o_busy
);

    localparam int PROG_LEN = 9;

    // each date runs steps 0..6; step 6 loops back once for the second date
    localparam cdd_pkg::t_uword PROG [PROG_LEN] = '{
        '{cdd_pkg::MUL_Y99,  cdd_pkg::ACC_NOP,      cdd_pkg::AUX_NONE,
          1'b0, 1'b0, 1'b0, 4'd0},
        '{cdd_pkg::MUL_Y,    cdd_pkg::ACC_LOAD_Q4,  cdd_pkg::AUX_Q100,
          1'b0, 1'b0, 1'b0, 4'd0},
        '{cdd_pkg::MUL_Y399, cdd_pkg::ACC_SUB_Q,    cdd_pkg::AUX_CHK100,
          1'b0, 1'b0, 1'b0, 4'd0},
        '{cdd_pkg::MUL_Y365, cdd_pkg::ACC_ADD_Q400, cdd_pkg::AUX_LEAP,
          1'b0, 1'b0, 1'b0, 4'd0},
        '{cdd_pkg::MUL_NONE, cdd_pkg::ACC_ADD_PROD, cdd_pkg::AUX_NONE,
          1'b0, 1'b0, 1'b0, 4'd0},
        '{cdd_pkg::MUL_NONE, cdd_pkg::ACC_ADD_MON,  cdd_pkg::AUX_VALID,
          1'b0, 1'b0, 1'b0, 4'd0},
        '{cdd_pkg::MUL_NONE, cdd_pkg::ACC_NOP,      cdd_pkg::AUX_NONE,
          1'b1, 1'b1, 1'b0, 4'd0},
        '{cdd_pkg::MUL_NONE, cdd_pkg::ACC_ABSDIFF,  cdd_pkg::AUX_NONE,
          1'b0, 1'b0, 1'b0, 4'd0},
        '{cdd_pkg::MUL_NONE, cdd_pkg::ACC_NOP,      cdd_pkg::AUX_NONE,
          1'b0, 1'b0, 1'b1, 4'd0}
    };

    logic                     r_busy, n_busy;
    logic                     r_sel, n_sel;
    logic [cdd_pkg::PC_W-1:0] r_pc, n_pc;
    cdd_pkg::t_uword          word;
    logic                     run;

    always_comb begin
        word = (r_pc < cdd_pkg::PC_W'(PROG_LEN)) ? PROG[r_pc] : PROG[PROG_LEN-1];
        run  = r_busy && !(word.last && i_hold);
    end

    always_comb begin
        n_busy = r_busy;
        n_sel  = r_sel;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_sel  = 1'b0;
                n_pc   = '0;
            end
        end else if (run) begin
            if (word.last) begin
                n_busy = 1'b0;
            end else if (word.branch && !r_sel) begin
                n_sel = 1'b1;
                n_pc  = word.target;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sel  <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_sel  <= n_sel;
            r_pc   <= n_pc;
        end
    end

    assign o_ctl.run = run;
    assign o_ctl.sel = r_sel;
    assign o_ctl.w   = word;
    assign o_busy    = r_busy;

endmodule
`default_nettype wire

### hdl/cdd_dpath.sv
// Datapath: input word, shared multiplier, accumulator, leap and validity flags, result register.
`default_nettype none
module cdd_dpath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_load,
    input  wire logic [cdd_pkg::DAY_W-1:0]          i_day_a,
    input  wire logic [cdd_pkg::MONTH_W-1:0]        i_month_a,
    input  wire logic [cdd_pkg::YEAR_W-1:0]         i_year_a,
    input  wire logic [cdd_pkg::DAY_W-1:0]          i_day_b,
    input  wire logic [cdd_pkg::MONTH_W-1:0]        i_month_b,
    input  wire logic [cdd_pkg::YEAR_W-1:0]         i_year_b,
    input  wire cdd_pkg::t_ctl                      i_ctl,
    input  wire logic                               i_out_ready,
    output logic                                    o_hold,
    output logic                                    o_out_valid,
    output logic signed [cdd_pkg::ORDER_W-1:0]      o_order,
    output logic [cdd_pkg::DIST_W-1:0]              o_days_apart,
    output logic                                    o_first_valid,
    output logic                                    o_second_valid
);

    logic [cdd_pkg::DAY_W-1:0]   r_da, r_db;
    logic [cdd_pkg::MONTH_W-1:0] r_ma, r_mb;
    logic [cdd_pkg::YEAR_W-1:0]  r_ya, r_yb;

    logic [cdd_pkg::PROD_W-1:0]  r_prod;
    logic [cdd_pkg::SER_W-1:0]   r_acc, r_sa;
    logic [7:0]                  r_q;      // floor((y+99)/100)
    logic [6:0]                  r_q4;     // floor(y/400)
    logic                        r_nd100;  // y not a multiple of 100
    logic                        r_leap;
    logic                        r_va, r_vb;

    logic                        r_ovalid;
    logic signed [cdd_pkg::ORDER_W-1:0] r_order;
    logic [cdd_pkg::DIST_W-1:0]  r_dist;
    logic                        r_fva, r_fvb;

    logic [cdd_pkg::DAY_W-1:0]   d;
    logic [cdd_pkg::MONTH_W-1:0] m;
    logic [cdd_pkg::MUL_W-1:0]   y15, y3, mul_a, mul_b;
    logic [8:0]                  q100;
    logic [6:0]                  q400;
    logic [12:0]                 q4;
    logic [cdd_pkg::SER_W-1:0]   mon_term;
    logic [cdd_pkg::SER_W:0]     diff_sa;
    logic [cdd_pkg::SER_W-1:0]   absdiff;
    logic                        leap_now, date_ok;
    logic                        a_gt, a_lt;
    logic [cdd_pkg::DIST_W-1:0]  dist_sat;

    always_comb begin
        d    = i_ctl.sel ? r_db : r_da;
        m    = i_ctl.sel ? r_mb : r_ma;
        y15  = cdd_pkg::MUL_W'(i_ctl.sel ? r_yb : r_ya);
        y3   = y15 + 15'd3;
        q4   = y3[cdd_pkg::MUL_W-1:2];
        q100 = r_prod[cdd_pkg::PROD_W-1:21];
        q400 = r_prod[cdd_pkg::PROD_W-1:23];

        case (i_ctl.w.mul_sel)
            cdd_pkg::MUL_Y99:  mul_a = y15 + 15'd99;
            cdd_pkg::MUL_Y399: mul_a = y15 + 15'd399;
            default:           mul_a = y15;
        endcase
        mul_b = (i_ctl.w.mul_sel == cdd_pkg::MUL_Y365) ? cdd_pkg::DAYS_YEAR
                                                      : cdd_pkg::RECIP100;

        leap_now = (y15[1:0] == 2'b00) && (r_nd100 || (q400 == r_q4));
        date_ok  = (m inside {[4'd1:4'd12]}) && (d != '0) &&
                   (d <= cdd_pkg::f_mon_len(m, r_leap));
        mon_term = cdd_pkg::SER_W'(cdd_pkg::f_mon_start(m)) + cdd_pkg::SER_W'(d)
                 + cdd_pkg::SER_W'((m > 4'd2) && r_leap);

        diff_sa = {1'b0, r_sa} - {1'b0, r_acc};
        absdiff = diff_sa[cdd_pkg::SER_W] ? (r_acc - r_sa) : diff_sa[cdd_pkg::SER_W-1:0];
    end

    // ordering on raw fields: year, then month, then day
    always_comb begin
        a_gt = {r_ya, r_ma, r_da} > {r_yb, r_mb, r_db};
        a_lt = {r_ya, r_ma, r_da} < {r_yb, r_mb, r_db};
        if (!(r_va && r_vb))
            dist_sat = '0;
        else if (r_acc > cdd_pkg::SER_W'(cdd_pkg::DAYS_MAX))
            dist_sat = cdd_pkg::DAYS_MAX;
        else
            dist_sat = r_acc[cdd_pkg::DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_da <= i_day_a;
            r_ma <= i_month_a;
            r_ya <= i_year_a;
            r_db <= i_day_b;
            r_mb <= i_month_b;
            r_yb <= i_year_b;
        end
        if (i_ctl.run) begin
            if (i_ctl.w.mul_sel != cdd_pkg::MUL_NONE)
                r_prod <= cdd_pkg::PROD_W'(mul_a) * cdd_pkg::PROD_W'(mul_b);

            case (i_ctl.w.acc_op)
                cdd_pkg::ACC_LOAD_Q4:  r_acc <= cdd_pkg::SER_W'(q4);
                cdd_pkg::ACC_SUB_Q:    r_acc <= r_acc - cdd_pkg::SER_W'(r_q);
                cdd_pkg::ACC_ADD_Q400: r_acc <= r_acc + cdd_pkg::SER_W'(q400);
                cdd_pkg::ACC_ADD_PROD: r_acc <= r_acc + r_prod[cdd_pkg::SER_W-1:0];
                cdd_pkg::ACC_ADD_MON:  r_acc <= r_acc + mon_term;
                cdd_pkg::ACC_ABSDIFF:  r_acc <= absdiff;
                default:               r_acc <= r_acc;
            endcase

            case (i_ctl.w.aux_op)
                cdd_pkg::AUX_Q100: r_q <= q100[7:0];
                cdd_pkg::AUX_CHK100: begin
                    r_nd100 <= (q100[7:0] != r_q);
                    r_q4    <= q100[8:2];
                end
                cdd_pkg::AUX_LEAP: r_leap <= leap_now;
                cdd_pkg::AUX_VALID: begin
                    if (i_ctl.sel)
                        r_vb <= date_ok;
                    else
                        r_va <= date_ok;
                end
                default: ;
            endcase

            if (i_ctl.w.store && !i_ctl.sel)
                r_sa <= r_acc;

            if (i_ctl.w.last) begin
                r_order <= a_gt ? 2'sb01 : (a_lt ? 2'sb11 : 2'sb00);
                r_dist  <= dist_sat;
                r_fva   <= r_va;
                r_fvb   <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.run && i_ctl.w.last) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_hold         = r_ovalid && !i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_order        = r_order;
    assign o_days_apart   = r_dist;
    assign o_first_valid  = r_fva;
    assign o_second_valid = r_fvb;

endmodule
`default_nettype wire
